[hw/rtl/utrb_pkg.sv]
// ----------------------------------------------------------------------------
// utrb_pkg: shared definitions for the UART ring-buffer block
// Depths, event and status codes, and the command and result structs that
// pass between the controller and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package utrb_pkg;

  // Slots per ring. One slot always stays empty, so a ring holds depth-1 bytes.
  localparam int TX_DEPTH = 16;
  localparam int RX_DEPTH = 16;

  // Width of a cell index and of a fill count (the count never exceeds depth-1).
  localparam int TX_IW = $clog2(TX_DEPTH);
  localparam int RX_IW = $clog2(RX_DEPTH);

  // Event codes carried in the mode field.
  localparam logic [1:0] MODE_PUT     = 2'd0;
  localparam logic [1:0] MODE_GET     = 2'd1;
  localparam logic [1:0] MODE_TX_DONE = 2'd2;
  localparam logic [1:0] MODE_RX_BYTE = 2'd3;

  // Status codes returned with every result.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_TX_FULL  = 3'd1;
  localparam logic [2:0] ST_RX_EMPTY = 3'd2;
  localparam logic [2:0] ST_RX_OVFL  = 3'd3;
  localparam logic [2:0] ST_RX_ERR   = 3'd4;

  // Per-chain command: push writes data_in at wr_pos, pop shifts every
  // cell one place toward the front.
  typedef struct packed {
    logic             push;
    logic             pop;
    logic [TX_IW-1:0] wr_pos;
  } tx_cmd_t;

  typedef struct packed {
    logic             push;
    logic             pop;
    logic [RX_IW-1:0] wr_pos;
  } rx_cmd_t;

  // One result beat.
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] read_byte;
    logic       send_valid;
    logic [7:0] send_byte;
    logic [3:0] tx_free;
    logic       rx_present;
    logic       tx_irq_armed;
  } res_t;

endpackage

`default_nettype wire

[hw/rtl/utrb_cell.sv]
// ----------------------------------------------------------------------------
// utrb_cell: one byte slot of a shifting FIFO chain
// Loads the incoming byte when selected, otherwise takes its neighbor's byte
// when the chain shifts toward the front.
// ----------------------------------------------------------------------------
`default_nettype none

module utrb_cell (
  input  wire logic       clk,
  input  wire logic       load,
  input  wire logic       shift,
  input  wire logic [7:0] din,
  input  wire logic [7:0] nbr,
  output logic      [7:0] q
);

  logic [7:0] q_r;
  logic [7:0] q_nxt;

  // A load wins over a shift: on a simultaneous push and pop the new byte
  // lands in the cell that the shift would otherwise leave stale.
  always_comb begin
    q_nxt = q_r;
    if (load) begin
      q_nxt = din;
    end else if (shift) begin
      q_nxt = nbr;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

`default_nettype wire

[hw/rtl/utrb_ctrl.sv]
// ----------------------------------------------------------------------------
// utrb_ctrl: fill counts, interrupt flag and event decode
// Turns one accepted event into push/pop commands for both cell chains and
// forms the result beat from the state after the event.
// ----------------------------------------------------------------------------
`default_nettype none

module utrb_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  accept,
  input  wire logic [1:0]            mode,
  input  wire logic [7:0]            data_in,
  input  wire logic                  line_error,
  input  wire logic                  tx_idle,
  input  wire logic [7:0]            tx_front,
  input  wire logic [7:0]            rx_front,
  output utrb_pkg::tx_cmd_t          tx_cmd,
  output utrb_pkg::rx_cmd_t          rx_cmd,
  output utrb_pkg::res_t             res
);

  logic [utrb_pkg::TX_IW-1:0] tx_cnt_r;
  logic [utrb_pkg::TX_IW-1:0] tx_cnt_nxt;
  logic [utrb_pkg::RX_IW-1:0] rx_cnt_r;
  logic [utrb_pkg::RX_IW-1:0] rx_cnt_nxt;
  logic                       tx_armed_r;
  logic                       tx_armed_nxt;

  logic                       tx_full;
  logic                       tx_empty;
  logic                       rx_full;
  logic                       rx_empty;
  logic [utrb_pkg::TX_IW-1:0] tx_free_raw;
  logic [8:0]                 tx_free_wide;

  assign tx_full  = (tx_cnt_r == utrb_pkg::TX_IW'(utrb_pkg::TX_DEPTH - 1));
  assign tx_empty = (tx_cnt_r == '0);
  assign rx_full  = (rx_cnt_r == utrb_pkg::RX_IW'(utrb_pkg::RX_DEPTH - 1));
  assign rx_empty = (rx_cnt_r == '0);

  always_comb begin
    tx_cmd         = '0;
    rx_cmd         = '0;
    tx_cnt_nxt     = tx_cnt_r;
    rx_cnt_nxt     = rx_cnt_r;
    tx_armed_nxt   = tx_armed_r;
    res            = '0;
    res.status     = utrb_pkg::ST_OK;

    if (accept) begin
      case (mode)
        utrb_pkg::MODE_PUT: begin
          if (tx_full) begin
            res.status = utrb_pkg::ST_TX_FULL;
          end else begin
            tx_armed_nxt = 1'b1;
            if (tx_idle) begin
              // Queue and send in the same beat. On an empty ring the new
              // byte goes straight out and never occupies a cell.
              res.send_valid = 1'b1;
              if (tx_empty) begin
                res.send_byte = data_in;
              end else begin
                res.send_byte = tx_front;
                tx_cmd.pop    = 1'b1;
                tx_cmd.push   = 1'b1;
                tx_cmd.wr_pos = tx_cnt_r - 1'b1;
              end
            end else begin
              tx_cmd.push   = 1'b1;
              tx_cmd.wr_pos = tx_cnt_r;
              tx_cnt_nxt    = tx_cnt_r + 1'b1;
            end
          end
        end
        utrb_pkg::MODE_GET: begin
          if (rx_empty) begin
            res.status = utrb_pkg::ST_RX_EMPTY;
          end else begin
            res.read_byte = rx_front;
            rx_cmd.pop    = 1'b1;
            rx_cnt_nxt    = rx_cnt_r - 1'b1;
          end
        end
        utrb_pkg::MODE_TX_DONE: begin
          if (tx_empty) begin
            tx_armed_nxt = 1'b0;
          end else begin
            res.send_valid = 1'b1;
            res.send_byte  = tx_front;
            tx_cmd.pop     = 1'b1;
            tx_cnt_nxt     = tx_cnt_r - 1'b1;
          end
        end
        utrb_pkg::MODE_RX_BYTE: begin
          if (line_error) begin
            res.status = utrb_pkg::ST_RX_ERR;
          end else if (rx_full) begin
            res.status = utrb_pkg::ST_RX_OVFL;
          end else begin
            rx_cmd.push   = 1'b1;
            rx_cmd.wr_pos = rx_cnt_r;
            rx_cnt_nxt    = rx_cnt_r + 1'b1;
          end
        end
        default: begin
          res.status = utrb_pkg::ST_OK;
        end
      endcase
    end

    // Status fields reflect the state after this event.
    tx_free_raw      = utrb_pkg::TX_IW'(utrb_pkg::TX_DEPTH - 1) - tx_cnt_nxt;
    tx_free_wide     = 9'(tx_free_raw);
    res.rx_present   = (rx_cnt_nxt != '0);
    res.tx_irq_armed = tx_armed_nxt;
    res.tx_free      = (tx_free_wide > 9'd15) ? 4'd15 : tx_free_wide[3:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_cnt_r   <= '0;
      rx_cnt_r   <= '0;
      tx_armed_r <= 1'b0;
    end else begin
      tx_cnt_r   <= tx_cnt_nxt;
      rx_cnt_r   <= rx_cnt_nxt;
      tx_armed_r <= tx_armed_nxt;
    end
  end

  // Fill counts stay within the usable capacity of each ring.
  a_tx_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    tx_cnt_r <= utrb_pkg::TX_IW'(utrb_pkg::TX_DEPTH - 1))
    else $error("transmit fill count beyond capacity");

  a_rx_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    rx_cnt_r <= utrb_pkg::RX_IW'(utrb_pkg::RX_DEPTH - 1))
    else $error("receive fill count beyond capacity");

  // A put that is not refused leaves the interrupt armed.
  a_put_arms: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && mode == utrb_pkg::MODE_PUT && !tx_full) |=> tx_armed_r)
    else $error("accepted put did not arm transmit interrupt");

  // A transmit-complete on an empty ring disarms and leaves the ring empty.
  a_done_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && mode == utrb_pkg::MODE_TX_DONE && tx_empty)
      |=> (!tx_armed_r && tx_cnt_r == '0))
    else $error("transmit complete on empty ring did not disarm");

  // A get on a nonempty ring removes exactly one byte.
  a_get_pops: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && mode == utrb_pkg::MODE_GET && !rx_empty)
      |=> (rx_cnt_r == $past(rx_cnt_r) - 1'b1))
    else $error("get did not remove one byte");

endmodule

`default_nettype wire

[hw/rtl/uart_tx_rx_ring_buffers_top.sv]
// ----------------------------------------------------------------------------
// uart_tx_rx_ring_buffers_top: transmit and receive byte FIFOs for a UART
// Two shifting cell chains hold the queued bytes, a controller keeps the
// fill counts and the transmit interrupt flag, and an output register holds
// one result beat for the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

// Every input beat is one event: a software put, a software get, a
// transmit-complete from the UART, or a received byte, and every event gives
// exactly one result beat with a status code, the byte read by a get, the
// byte handed to the transmitter, the free transmit space, receive presence
// and the transmit interrupt flag after the event. Each ring holds depth-1
// bytes (15 with the default depth of 16). The block takes one beat per
// clock cycle; the only limit is the single output register, so while a
// result waits under out_stall the input is stalled, and it frees again in
// the cycle in which the result is taken. Each ring is a chain of byte cells
// with the oldest byte always in the first cell: a pop shifts the whole chain
// one place toward the front at once, and a push writes the cell just
// past the last queued byte. After reset both rings are empty and the
// interrupt is disarmed; no clearing pass is needed.

module uart_tx_rx_ring_buffers_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Event channel.
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_mode,
  input  wire logic [7:0] in_data_in,
  input  wire logic       in_line_error,
  input  wire logic       in_tx_idle,
  // Result channel.
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [2:0] out_status,
  output logic      [7:0] out_read_byte,
  output logic            out_send_valid,
  output logic      [7:0] out_send_byte,
  output logic      [3:0] out_tx_free,
  output logic            out_rx_present,
  output logic            out_tx_irq_armed
);

  logic              in_acc;
  logic              out_valid_r;
  logic              out_valid_nxt;
  utrb_pkg::res_t    res;
  utrb_pkg::res_t    res_r;
  utrb_pkg::tx_cmd_t tx_cmd;
  utrb_pkg::rx_cmd_t rx_cmd;

  logic [7:0] tx_q [utrb_pkg::TX_DEPTH];
  logic [7:0] rx_q [utrb_pkg::RX_DEPTH];

  // The output register is the only buffer: a new beat can enter whenever
  // that register is empty or being taken in this cycle.
  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  utrb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_acc),
    .mode       (in_mode),
    .data_in    (in_data_in),
    .line_error (in_line_error),
    .tx_idle    (in_tx_idle),
    .tx_front   (tx_q[0]),
    .rx_front   (rx_q[0]),
    .tx_cmd     (tx_cmd),
    .rx_cmd     (rx_cmd),
    .res        (res)
  );

  // Transmit chain. Cell 0 always holds the oldest queued byte; the last
  // cell shifts in zero, which is never read as a queued byte.
  for (genvar i = 0; i < utrb_pkg::TX_DEPTH; i++) begin : g_tx
    logic [7:0] nbr;
    if (i == utrb_pkg::TX_DEPTH - 1) begin : g_last
      assign nbr = 8'h00;
    end else begin : g_mid
      assign nbr = tx_q[i+1];
    end
    utrb_cell u_cell (
      .clk   (clk),
      .load  (tx_cmd.push && (tx_cmd.wr_pos == utrb_pkg::TX_IW'(i))),
      .shift (tx_cmd.pop),
      .din   (in_data_in),
      .nbr   (nbr),
      .q     (tx_q[i])
    );
  end

  // Receive chain, built the same way.
  for (genvar i = 0; i < utrb_pkg::RX_DEPTH; i++) begin : g_rx
    logic [7:0] nbr;
    if (i == utrb_pkg::RX_DEPTH - 1) begin : g_last
      assign nbr = 8'h00;
    end else begin : g_mid
      assign nbr = rx_q[i+1];
    end
    utrb_cell u_cell (
      .clk   (clk),
      .load  (rx_cmd.push && (rx_cmd.wr_pos == utrb_pkg::RX_IW'(i))),
      .shift (rx_cmd.pop),
      .din   (in_data_in),
      .nbr   (nbr),
      .q     (rx_q[i])
    );
  end

  // Result register. Valid is cleared only when the beat is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = res_r.status;
  assign out_read_byte    = res_r.read_byte;
  assign out_send_valid   = res_r.send_valid;
  assign out_send_byte    = res_r.send_byte;
  assign out_tx_free      = res_r.tx_free;
  assign out_rx_present   = res_r.rx_present;
  assign out_tx_irq_armed = res_r.tx_irq_armed;

endmodule

`default_nettype wire
